[rtl/core/vcs_pkg.sv]
// Package for the streaming 2D valid convolution unit.
// Holds sizes, field widths, register indexes and reset values.
// No dependencies; used by the top level and its checker.
package vcs_pkg;

  // Largest kernel edge and longest line the line buffer holds.
  localparam int unsigned KERNEL_MAX = 5;
  localparam int unsigned LINE_MAX   = 1024;
  localparam int unsigned ROWS_MAX   = 1024;

  // Field widths fixed by the interface.
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned COEF_IDX_W = 5;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned KDIM_W     = 3;
  localparam int unsigned ACC_W      = 40;

  // Derived widths.
  localparam int unsigned PROD_W   = PIX_W + COEF_W;
  localparam int unsigned ROWSUM_W = PROD_W + $clog2(KERNEL_MAX + 1);
  localparam int unsigned KIDX_W   = (KERNEL_MAX > 1) ? $clog2(KERNEL_MAX) : 1;
  localparam int unsigned CIDX_W   = (KERNEL_MAX > 1) ? $clog2(KERNEL_MAX * KERNEL_MAX) : 1;
  localparam int unsigned LINE_AW  = $clog2(LINE_MAX);

  // Configuration port.
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    REG_IMAGE_ROWS  = 2'd0,
    REG_IMAGE_COLS  = 2'd1,
    REG_KERNEL_ROWS = 2'd2,
    REG_KERNEL_COLS = 2'd3
  } reg_idx_e;

  localparam logic [DIM_W-1:0]  IMAGE_ROWS_RST  = DIM_W'(28);
  localparam logic [DIM_W-1:0]  IMAGE_COLS_RST  = DIM_W'(28);
  localparam logic [KDIM_W-1:0] KERNEL_ROWS_RST = KDIM_W'(3);
  localparam logic [KDIM_W-1:0] KERNEL_COLS_RST = KDIM_W'(3);

  // Request type codes.
  localparam logic REQ_COEF  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // Position information that travels with a result.
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } res_meta_t;

endpackage

[rtl/core/valid_conv2d_stream_unit.sv]
// Top level of the streaming 2D valid convolution unit.
// Line buffer, window registers, multiplier array, adder stages and output skid.
// Depends on vcs_pkg.

// The unit takes one item per clock while in_ready_o is high: a coefficient
// write or a raster-order pixel. A pixel that completes a full kernel window
// yields one result. The line memory is read at the edge that accepts it, and the
// window shift, multiplier array, row sums and output register follow. Results
// pass through an output register backed by a one-entry skid buffer. in_ready_o
// drops only when both hold results that the sink has not taken, and it returns
// the cycle after the sink takes one. The line buffer is one 1024 x 16 bit memory
// per kernel row. Every memory is read once per pixel, and only the memory of the
// current row is written. Any register write restarts the frame at row 0, column 0.
module valid_conv2d_stream_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [vcs_pkg::COEF_IDX_W-1:0]      coef_index_i,
  input  logic signed [vcs_pkg::COEF_W-1:0]   coef_value_i,
  input  logic signed [vcs_pkg::PIX_W-1:0]    pixel_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [vcs_pkg::ACC_W-1:0]    conv_value_o,
  output logic [vcs_pkg::POS_W-1:0]           out_row_o,
  output logic [vcs_pkg::POS_W-1:0]           out_col_o,
  output logic                                last_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vcs_pkg::ADDR_W-1:0]          paddr,
  input  logic [vcs_pkg::DATA_W-1:0]          pwdata,
  output logic [vcs_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  localparam int unsigned K = vcs_pkg::KERNEL_MAX;

  // ---------------------------------------------------------------- config
  logic [vcs_pkg::DIM_W-1:0]  img_rows_q, img_cols_q;
  logic [vcs_pkg::KDIM_W-1:0] krn_rows_q, krn_cols_q;
  logic                       cfg_we;
  vcs_pkg::reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = vcs_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_rows_q <= vcs_pkg::IMAGE_ROWS_RST;
      img_cols_q <= vcs_pkg::IMAGE_COLS_RST;
      krn_rows_q <= vcs_pkg::KERNEL_ROWS_RST;
      krn_cols_q <= vcs_pkg::KERNEL_COLS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        vcs_pkg::REG_IMAGE_ROWS:  img_rows_q <= pwdata[vcs_pkg::DIM_W-1:0];
        vcs_pkg::REG_IMAGE_COLS:  img_cols_q <= pwdata[vcs_pkg::DIM_W-1:0];
        vcs_pkg::REG_KERNEL_ROWS: krn_rows_q <= pwdata[vcs_pkg::KDIM_W-1:0];
        vcs_pkg::REG_KERNEL_COLS: krn_cols_q <= pwdata[vcs_pkg::KDIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      vcs_pkg::REG_IMAGE_ROWS:  prdata = vcs_pkg::DATA_W'(img_rows_q);
      vcs_pkg::REG_IMAGE_COLS:  prdata = vcs_pkg::DATA_W'(img_cols_q);
      vcs_pkg::REG_KERNEL_ROWS: prdata = vcs_pkg::DATA_W'(krn_rows_q);
      vcs_pkg::REG_KERNEL_COLS: prdata = vcs_pkg::DATA_W'(krn_cols_q);
      default:                  prdata = '0;
    endcase
  end

  // Register values as used: zero reads as one, larger values are capped.
  logic [vcs_pkg::DIM_W-1:0]  rows_eff, cols_eff;
  logic [vcs_pkg::KDIM_W-1:0] kr_eff, kc_eff;

  always_comb begin
    if (img_rows_q == '0) rows_eff = vcs_pkg::DIM_W'(1);
    else if (img_rows_q > vcs_pkg::DIM_W'(vcs_pkg::ROWS_MAX))
      rows_eff = vcs_pkg::DIM_W'(vcs_pkg::ROWS_MAX);
    else rows_eff = img_rows_q;

    if (img_cols_q == '0) cols_eff = vcs_pkg::DIM_W'(1);
    else if (img_cols_q > vcs_pkg::DIM_W'(vcs_pkg::LINE_MAX))
      cols_eff = vcs_pkg::DIM_W'(vcs_pkg::LINE_MAX);
    else cols_eff = img_cols_q;

    if (krn_rows_q == '0) kr_eff = vcs_pkg::KDIM_W'(1);
    else if (krn_rows_q > vcs_pkg::KDIM_W'(K)) kr_eff = vcs_pkg::KDIM_W'(K);
    else kr_eff = krn_rows_q;

    if (krn_cols_q == '0) kc_eff = vcs_pkg::KDIM_W'(1);
    else if (krn_cols_q > vcs_pkg::KDIM_W'(K)) kc_eff = vcs_pkg::KDIM_W'(K);
    else kc_eff = krn_cols_q;
  end

  // ------------------------------------------------------------ input side
  logic adv, acc, acc_pix, acc_coef, coef_in_use;
  logic skid_v_q;

  assign adv        = ~skid_v_q;
  assign in_ready_o = adv;
  assign acc        = in_valid_i & adv;
  assign acc_pix    = acc & (req_type_i == vcs_pkg::REQ_PIXEL);
  assign acc_coef   = acc & (req_type_i == vcs_pkg::REQ_COEF);
  assign coef_in_use = int'(coef_index_i) < int'(kr_eff) * int'(kc_eff);

  // Raster position of the next pixel and the line bank of its row.
  logic [vcs_pkg::POS_W-1:0]  row_q, col_q;
  logic [vcs_pkg::KIDX_W-1:0] bank_q;
  logic                       win_full, row_end, col_end, frame_last;
  vcs_pkg::res_meta_t         meta_d;

  assign win_full = (row_q >= vcs_pkg::POS_W'(kr_eff - vcs_pkg::KDIM_W'(1))) &&
                    (col_q >= vcs_pkg::POS_W'(kc_eff - vcs_pkg::KDIM_W'(1)));
  assign col_end  = ({1'b0, col_q} + vcs_pkg::DIM_W'(1)) >= cols_eff;
  assign row_end  = ({1'b0, row_q} + vcs_pkg::DIM_W'(1)) >= rows_eff;
  assign frame_last = ({1'b0, row_q} == rows_eff - vcs_pkg::DIM_W'(1)) &&
                      ({1'b0, col_q} == cols_eff - vcs_pkg::DIM_W'(1));

  always_comb begin
    meta_d.row  = row_q - vcs_pkg::POS_W'(kr_eff - vcs_pkg::KDIM_W'(1));
    meta_d.col  = col_q - vcs_pkg::POS_W'(kc_eff - vcs_pkg::KDIM_W'(1));
    meta_d.last = frame_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      bank_q <= '0;
    end else if (cfg_we) begin
      row_q  <= '0;
      col_q  <= '0;
      bank_q <= '0;
    end else if (acc_pix) begin
      if (col_end) begin
        col_q <= '0;
        if (row_end) begin
          row_q  <= '0;
          bank_q <= '0;
        end else begin
          row_q  <= row_q + vcs_pkg::POS_W'(1);
          bank_q <= (bank_q == vcs_pkg::KIDX_W'(K - 1)) ? '0 : bank_q + vcs_pkg::KIDX_W'(1);
        end
      end else begin
        col_q <= col_q + vcs_pkg::POS_W'(1);
      end
    end
  end

  // ----------------------------------------------------------- line buffer
  // Image row r lives in bank r mod KERNEL_MAX. Every bank is read at the
  // current column; the current row's value comes straight from the pixel.
  logic signed [vcs_pkg::PIX_W-1:0] line_rd_q [K];

  for (genvar b = 0; b < K; b++) begin : g_bank
    logic signed [vcs_pkg::PIX_W-1:0] line_mem [vcs_pkg::LINE_MAX];

    always_ff @(posedge clk_i) begin
      if (acc_pix && (bank_q == vcs_pkg::KIDX_W'(b))) begin
        line_mem[col_q[vcs_pkg::LINE_AW-1:0]] <= pixel_i;
      end
      if (acc_pix) begin
        line_rd_q[b] <= line_mem[col_q[vcs_pkg::LINE_AW-1:0]];
      end
    end
  end

  // --------------------------------------------------------------- stage 1
  logic                             s1_shift_q, s1_res_q, s1_cwe_q;
  logic signed [vcs_pkg::PIX_W-1:0] s1_pixel_q;
  logic [vcs_pkg::KIDX_W-1:0]       s1_bank_q;
  vcs_pkg::res_meta_t               s1_meta_q;
  logic [vcs_pkg::CIDX_W-1:0]       s1_cidx_q;
  logic signed [vcs_pkg::COEF_W-1:0] s1_cval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_shift_q <= 1'b0;
      s1_res_q   <= 1'b0;
      s1_cwe_q   <= 1'b0;
    end else if (adv) begin
      s1_shift_q <= acc_pix;
      s1_res_q   <= acc_pix & win_full;
      s1_cwe_q   <= acc_coef & coef_in_use;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pixel_q <= pixel_i;
      s1_bank_q  <= bank_q;
      s1_meta_q  <= meta_d;
      s1_cidx_q  <= vcs_pkg::CIDX_W'(coef_index_i);
      s1_cval_q  <= coef_value_i;
    end
  end

  // --------------------------------------------------------------- stage 2
  // Window column: entry d holds the pixel d rows above the current one.
  logic signed [vcs_pkg::PIX_W-1:0] col_d [K];
  logic signed [vcs_pkg::PIX_W-1:0] win_q [K][K];
  logic                             s2_res_q, s2_cwe_q;
  vcs_pkg::res_meta_t               s2_meta_q;
  logic [vcs_pkg::CIDX_W-1:0]       s2_cidx_q;
  logic signed [vcs_pkg::COEF_W-1:0] s2_cval_q;

  always_comb begin
    logic [vcs_pkg::KIDX_W-1:0] sel;
    sel      = '0;
    col_d[0] = s1_pixel_q;
    for (int d = 1; d < K; d++) begin
      if (s1_bank_q >= vcs_pkg::KIDX_W'(d)) sel = s1_bank_q - vcs_pkg::KIDX_W'(d);
      else sel = s1_bank_q + vcs_pkg::KIDX_W'(K - d);
      col_d[d] = line_rd_q[sel];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_res_q <= 1'b0;
      s2_cwe_q <= 1'b0;
    end else if (adv) begin
      s2_res_q <= s1_res_q;
      s2_cwe_q <= s1_cwe_q;
    end
  end

  // The newest column enters at the high end; older columns move down.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_meta_q <= s1_meta_q;
      s2_cidx_q <= s1_cidx_q;
      s2_cval_q <= s1_cval_q;
      if (s1_shift_q) begin
        for (int j = 0; j < K - 1; j++) win_q[j] <= win_q[j + 1];
        win_q[K - 1] <= col_d;
      end
    end
  end

  // --------------------------------------------------------------- stage 3
  // Coefficient writes take effect here, in order with the pixels that read them.
  logic signed [vcs_pkg::COEF_W-1:0] coef_q [K * K];
  logic signed [vcs_pkg::PROD_W-1:0] prod_d [K][K];
  logic signed [vcs_pkg::PROD_W-1:0] prod_q [K][K];
  logic                              s3_res_q;
  vcs_pkg::res_meta_t                s3_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < K * K; i++) coef_q[i] <= '0;
    end else if (adv && s2_cwe_q) begin
      coef_q[s2_cidx_q] <= s2_cval_q;
    end
  end

  // Kernel tap (ki, kj) meets window column K-kc+kj at depth kr-1-ki.
  always_comb begin
    logic [vcs_pkg::KIDX_W-1:0] wj, dd;
    logic [vcs_pkg::CIDX_W-1:0] ci;
    wj = '0;
    dd = '0;
    ci = '0;
    for (int ki = 0; ki < K; ki++) begin
      for (int kj = 0; kj < K; kj++) begin
        prod_d[ki][kj] = '0;
        if ((ki < int'(kr_eff)) && (kj < int'(kc_eff))) begin
          wj = vcs_pkg::KIDX_W'(K - int'(kc_eff) + kj);
          dd = vcs_pkg::KIDX_W'(int'(kr_eff) - 1 - ki);
          ci = vcs_pkg::CIDX_W'(ki * int'(kc_eff) + kj);
          prod_d[ki][kj] = win_q[wj][dd] * coef_q[ci];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_res_q <= 1'b0;
    else if (adv) s3_res_q <= s2_res_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_meta_q <= s2_meta_q;
      if (s2_res_q) prod_q <= prod_d;
    end
  end

  // --------------------------------------------------------------- stage 4
  logic signed [vcs_pkg::ROWSUM_W-1:0] rowsum_d [K];
  logic signed [vcs_pkg::ROWSUM_W-1:0] rowsum_q [K];
  logic                                s4_res_q;
  vcs_pkg::res_meta_t                  s4_meta_q;

  always_comb begin
    for (int ki = 0; ki < K; ki++) begin
      rowsum_d[ki] = '0;
      for (int kj = 0; kj < K; kj++) begin
        rowsum_d[ki] = rowsum_d[ki] + vcs_pkg::ROWSUM_W'(prod_q[ki][kj]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_res_q <= 1'b0;
    else if (adv) s4_res_q <= s3_res_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_meta_q <= s3_meta_q;
      if (s3_res_q) rowsum_q <= rowsum_d;
    end
  end

  // ------------------------------------------------- output register + skid
  logic signed [vcs_pkg::ACC_W-1:0] sum_d;
  logic                             res_in;
  logic                             out_v_q;
  logic signed [vcs_pkg::ACC_W-1:0] out_conv_q, skid_conv_q;
  vcs_pkg::res_meta_t               out_meta_q, skid_meta_q;

  always_comb begin
    sum_d = '0;
    for (int ki = 0; ki < K; ki++) sum_d = sum_d + vcs_pkg::ACC_W'(rowsum_q[ki]);
  end

  assign res_in = adv & s4_res_q;

  // The skid entry fills only while the output register is stalled, and it
  // drains into the output register first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= res_in;
      end
    end else if (res_in) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_conv_q <= skid_conv_q;
        out_meta_q <= skid_meta_q;
      end else if (res_in) begin
        out_conv_q <= sum_d;
        out_meta_q <= s4_meta_q;
      end
    end else if (res_in) begin
      skid_conv_q <= sum_d;
      skid_meta_q <= s4_meta_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign conv_value_o = out_conv_q;
  assign out_row_o    = out_meta_q.row;
  assign out_col_o    = out_meta_q.col;
  assign last_o       = out_meta_q.last;

endmodule

[rtl/core/vcs_checker.sv]
// Port-level checker for the streaming 2D valid convolution unit.
// Watches the handshakes of the top level; bound to it at the end of this file.
// Depends on vcs_pkg.
module vcs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [vcs_pkg::ACC_W-1:0]    conv_value_o,
  input logic [vcs_pkg::POS_W-1:0]           out_row_o,
  input logic [vcs_pkg::POS_W-1:0]           out_col_o,
  input logic                                last_o
);

  // With no result on the output, the skid entry is empty and items flow.
  a_ready_when_out_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o
  ) else $error("input stalled with no result waiting");

  // The input only stalls after a result sat unaccepted on the output.
  a_stall_has_cause: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i)
  ) else $error("input stall without a held result");

  // One taken result frees the skid entry, so the input reopens next cycle.
  a_stall_release: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && out_ready_i |=> in_ready_o
  ) else $error("input stayed stalled after the sink took a result");

  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(conv_value_o) &&
      $stable(out_row_o) && $stable(out_col_o) && $stable(last_o)
  ) else $error("held result changed before it was taken");

endmodule

bind valid_conv2d_stream_unit vcs_checker u_vcs_checker (.*);
